// ----- rtl/spfs_pkg.sv -----
package spfs_pkg;

   localparam int NUM_MOTORS_DEFAULT = 20;
   localparam int NUM_JOINTS = 20;
   localparam int SWITCH_LEN = 11;
   localparam int POSE_HDR_LEN = 9;

   // Request kinds.
   localparam logic [1:0] KIND_SET_JOINT = 2'd0;
   localparam logic [1:0] KIND_SEND_POSE = 2'd1;
   localparam logic [1:0] KIND_SWITCH = 2'd2;

   localparam logic [15:0] TIME_RESET = 16'd100;

   localparam logic [4:0] JOINT_TO_MOTOR [NUM_JOINTS] = '{
      5'd8, 5'd10, 5'd9, 5'd11, 5'd12, 5'd13,
      5'd14, 5'd16, 5'd15, 5'd17, 5'd18, 5'd19,
      5'd0, 5'd1,
      5'd2, 5'd3, 5'd4,
      5'd5, 5'd6, 5'd7
   };

   // Bytes 1 and 8 are replaced by the length and motor count.
   localparam logic [7:0] POSE_HDR [POSE_HDR_LEN] = '{
      8'h53, 8'h00, 8'hfa, 8'haf, 8'h00, 8'h00, 8'h1e, 8'h05, 8'h00
   };

   // Bytes 4, 9 and 10 are replaced by motor, on flag and check byte.
   localparam logic [7:0] SWITCH_FRAME [SWITCH_LEN] = '{
      8'h53, 8'h09, 8'hfa, 8'haf, 8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h01, 8'h00
   };

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] joint_index;
      logic signed [15:0] angle_tenths;
      logic [15:0] move_time;
      logic servo_on;
   } req_type;

   typedef struct packed {
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic second_valid;
      logic last_beat;
   } rsp_type;

   typedef struct packed {
      logic write_slot;
      logic load_pose;
      logic load_switch;
      logic emit;
   } spfs_cmd_type;

   typedef struct packed {
      logic joint_ok;
      logic final_beat;
   } spfs_sts_type;

endpackage

// ----- rtl/spfs_ctrl.sv -----
module spfs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             kind,
   input  spfs_pkg::spfs_sts_type sts,
   output spfs_pkg::spfs_cmd_type cmd,
   output logic                   busy
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority if (kind == spfs_pkg::KIND_SET_JOINT) begin
                  cmd.write_slot = sts.joint_ok;
               end else if (kind == spfs_pkg::KIND_SEND_POSE) begin
                  cmd.load_pose = 1'b1;
                  state_in = ST_RUN;
               end else if (kind == spfs_pkg::KIND_SWITCH && sts.joint_ok) begin
                  cmd.load_switch = 1'b1;
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RUN: begin
            cmd.emit = 1'b1;
            if (sts.final_beat) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_RUN);

endmodule

// ----- rtl/spfs_dp.sv -----
module spfs_dp #(
   parameter int NUM_MOTORS = spfs_pkg::NUM_MOTORS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  spfs_pkg::req_type      req_item,
   input  spfs_pkg::spfs_cmd_type cmd,
   output spfs_pkg::spfs_sts_type sts,
   output logic                   rsp_strobe,
   output spfs_pkg::rsp_type      rsp_item
);

   localparam int MIDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam int MCNT_W = $clog2(NUM_MOTORS + 1);
   localparam int POSE_LEN = 5 * NUM_MOTORS + 10;
   localparam logic [7:0] POSE_LEN_B = 8'(POSE_LEN);
   localparam logic [7:0] LEN_BYTE = 8'((5 * NUM_MOTORS + 8) % 256);
   localparam logic [7:0] COUNT_BYTE = 8'(NUM_MOTORS % 256);

   logic [15:0] angle_ff [NUM_MOTORS];
   logic [15:0] time_ff [NUM_MOTORS];

   logic [7:0]        pos_ff, pos_in;
   logic [MCNT_W-1:0] motor_ff, motor_in;
   logic [2:0]        sub_ff, sub_in;
   logic [7:0]        xor_ff, xor_in;
   logic [7:0]        len_ff;
   logic              pose_ff;
   logic [7:0]        sw_motor_ff;
   logic              sw_on_ff;
   logic              rsp_strobe_ff;
   spfs_pkg::rsp_type rsp_ff, rsp_in;

   logic [4:0]        map_motor;
   logic              joint_ok;
   logic [31:0]       cur_data;
   logic [7:0]        pos2, chk_pos;
   logic [7:0]        mid1, mid2;
   logic [2:0]        sub2;
   logic [7:0]        raw1, raw2;
   logic              in1, in2, valid2;

   function automatic logic [7:0] frame_byte(
      input logic [7:0]  pos,
      input logic        pose,
      input logic [7:0]  mid,
      input logic [2:0]  sub,
      input logic [31:0] data,
      input logic [7:0]  sw_motor,
      input logic        sw_on
   );
      logic [7:0] b;
      b = 8'h00;
      if (pose) begin
         if (pos < 8'(spfs_pkg::POSE_HDR_LEN)) begin
            priority if (pos == 8'd1) begin
               b = LEN_BYTE;
            end else if (pos == 8'd8) begin
               b = COUNT_BYTE;
            end else begin
               b = spfs_pkg::POSE_HDR[pos[3:0]];
            end
         end else begin
            unique case (sub)
               3'd0: b = mid;
               3'd1: b = data[23:16];
               3'd2: b = data[31:24];
               3'd3: b = data[7:0];
               3'd4: b = data[15:8];
               default: b = 8'h00;
            endcase
         end
      end else if (pos < 8'(spfs_pkg::SWITCH_LEN)) begin
         priority if (pos == 8'd4) begin
            b = sw_motor;
         end else if (pos == 8'd9) begin
            b = {7'd0, sw_on};
         end else begin
            b = spfs_pkg::SWITCH_FRAME[pos[3:0]];
         end
      end
      return b;
   endfunction

   // Joint to motor mapping; a joint is usable only if its motor exists.
   always_comb begin
      map_motor = (req_item.joint_index < 5'(spfs_pkg::NUM_JOINTS)) ?
                  spfs_pkg::JOINT_TO_MOTOR[req_item.joint_index] : 5'd0;
      joint_ok = (req_item.joint_index < 5'(spfs_pkg::NUM_JOINTS)) &&
                 ({1'b0, map_motor} < 6'(NUM_MOTORS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MOTORS; i++) begin
            angle_ff[i] <= 16'd0;
            time_ff[i] <= spfs_pkg::TIME_RESET;
         end
      end else if (cmd.write_slot) begin
         angle_ff[map_motor[MIDX_W-1:0]] <= req_item.angle_tenths;
         time_ff[map_motor[MIDX_W-1:0]] <= req_item.move_time;
      end
   end

   // Only the motor of the first byte is read; a second byte that starts
   // the next motor is its id and needs no slot data.
   always_comb begin
      if (motor_ff < MCNT_W'(NUM_MOTORS)) begin
         cur_data = {angle_ff[motor_ff[MIDX_W-1:0]], time_ff[motor_ff[MIDX_W-1:0]]};
      end else begin
         cur_data = 32'd0;
      end

      pos2 = pos_ff + 8'd1;
      chk_pos = len_ff - 8'd1;
      mid1 = 8'(motor_ff) + 8'd1;
      if (pos_ff < 8'(spfs_pkg::POSE_HDR_LEN)) begin
         mid2 = 8'd1;
         sub2 = 3'd0;
      end else if (sub_ff == 3'd4) begin
         mid2 = 8'(motor_ff) + 8'd2;
         sub2 = 3'd0;
      end else begin
         mid2 = mid1;
         sub2 = sub_ff + 3'd1;
      end

      raw1 = frame_byte(pos_ff, pose_ff, mid1, sub_ff, cur_data, sw_motor_ff, sw_on_ff);
      raw2 = frame_byte(pos2, pose_ff, mid2, sub2, cur_data, sw_motor_ff, sw_on_ff);
      in1 = (pos_ff >= 8'd4) && (pos_ff < chk_pos);
      in2 = (pos2 >= 8'd4) && (pos2 < chk_pos);
      valid2 = (pos2 < len_ff);

      rsp_in.first_byte = (pos_ff == chk_pos) ? xor_ff : raw1;
      if (!valid2) begin
         rsp_in.second_byte = 8'h00;
      end else if (pos2 == chk_pos) begin
         rsp_in.second_byte = xor_ff ^ (in1 ? raw1 : 8'h00);
      end else begin
         rsp_in.second_byte = raw2;
      end
      rsp_in.second_valid = valid2;
      rsp_in.last_beat = ({1'b0, pos_ff} + 9'd2) >= {1'b0, len_ff};

      xor_in = xor_ff ^ (in1 ? raw1 : 8'h00) ^ (in2 ? raw2 : 8'h00);

      pos_in = pos_ff + 8'd2;
      motor_in = motor_ff;
      sub_in = sub_ff;
      if (pose_ff) begin
         if (pos_ff == 8'd8) begin
            motor_in = '0;
            sub_in = 3'd1;
         end else if (pos_ff >= 8'(spfs_pkg::POSE_HDR_LEN)) begin
            if (sub_ff >= 3'd3) begin
               sub_in = sub_ff - 3'd3;
               motor_in = motor_ff + MCNT_W'(1);
            end else begin
               sub_in = sub_ff + 3'd2;
            end
         end
      end
   end

   assign sts = '{joint_ok: joint_ok, final_beat: rsp_in.last_beat};

   always_ff @(posedge clock) begin
      if (cmd.load_pose || cmd.load_switch) begin
         pos_ff <= 8'd0;
         motor_ff <= '0;
         sub_ff <= 3'd0;
         xor_ff <= 8'h00;
         pose_ff <= cmd.load_pose;
         len_ff <= cmd.load_pose ? POSE_LEN_B : 8'(spfs_pkg::SWITCH_LEN);
         sw_motor_ff <= {3'd0, map_motor};
         sw_on_ff <= req_item.servo_on;
      end else if (cmd.emit) begin
         pos_ff <= pos_in;
         motor_ff <= motor_in;
         sub_ff <= sub_in;
         xor_ff <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

endmodule

// ----- rtl/servo_pose_frame_serializer.sv -----
// Channel   Ports                        Direction  Transfer
// request   start, busy, req_item        in         start high while busy low
// response  rsp_strobe, rsp_item         out        every cycle rsp_strobe is high
//
// A pose request is loaded, then sent as one beat for every two of its
// 5*NUM_MOTORS+10 bytes, rounded up, one beat a cycle; a switch request is sent
// the same way over its 11 bytes. A switch request with an unusable joint, a
// set-joint or an unknown request keeps it idle. Each beat leaves from a register.
// Synchronous reset loads every slot with angle 0 and move time 100.
// The receiver cannot stall; rsp_strobe marks each beat for one cycle only.
module servo_pose_frame_serializer #(
   parameter int NUM_MOTORS = spfs_pkg::NUM_MOTORS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  spfs_pkg::req_type req_item,
   output logic              rsp_strobe,
   output spfs_pkg::rsp_type rsp_item
);

   spfs_pkg::spfs_cmd_type cmd;
   spfs_pkg::spfs_sts_type sts;

   spfs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_item.kind),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   spfs_dp #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
